/* design/rgba_oc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_oc_pkg: shared types and constants for the rgba over compositor
// request and result layouts, the pipeline word and the arithmetic widths
// ----------------------------------------------------------------------------
package rgba_oc_pkg;

	localparam int CH_W   = 8;
	localparam int DEN_W  = 16;
	localparam int NUM_W  = 24;
	localparam int N_CH   = 3;
	localparam int QBIT_PER_STAGE = 2;

	localparam logic [CH_W-1:0] CH_MAX = 8'd255;

	// channel slots in the per-channel arrays
	localparam int CH_RED   = 0;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 2;

	typedef struct packed {
		logic [CH_W-1:0] fg_red;
		logic [CH_W-1:0] fg_green;
		logic [CH_W-1:0] fg_blue;
		logic [CH_W-1:0] fg_alpha;
		logic [CH_W-1:0] bg_red;
		logic [CH_W-1:0] bg_green;
		logic [CH_W-1:0] bg_blue;
		logic [CH_W-1:0] bg_alpha;
		logic            line_end_in;
		logic            frame_end_in;
	} pix_req_t;

	typedef struct packed {
		logic [CH_W-1:0] out_red;
		logic [CH_W-1:0] out_green;
		logic [CH_W-1:0] out_blue;
		logic [CH_W-1:0] out_alpha;
		logic            line_end_out;
		logic            frame_end_out;
	} pix_res_t;

	// word carried down the divider stages
	typedef struct packed {
		logic                       zero;
		logic [DEN_W-1:0]           den;
		logic [CH_W-1:0]            alpha;
		logic                       line_end;
		logic                       frame_end;
		logic [N_CH-1:0][NUM_W-1:0] rem;
		logic [N_CH-1:0][CH_W-1:0]  quot;
	} pipe_t;

endpackage
`default_nettype wire

/* design/rgba_oc_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_oc_front: numerator and denominator stages
// two register stages forming the blend numerators, D and the output alpha
// ----------------------------------------------------------------------------
module rgba_oc_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                vld,
	input  wire rgba_oc_pkg::pix_req_t req,
	output logic                     vld_out,
	output rgba_oc_pkg::pipe_t       word
);

	logic [rgba_oc_pkg::N_CH-1:0][rgba_oc_pkg::CH_W-1:0] fg_c;
	logic [rgba_oc_pkg::N_CH-1:0][rgba_oc_pkg::CH_W-1:0] bg_c;

	// stage 1 registers
	logic                                                   vld_s1;
	logic [rgba_oc_pkg::N_CH-1:0][rgba_oc_pkg::DEN_W-1:0]   fg_prod_s1;
	logic [rgba_oc_pkg::N_CH-1:0][rgba_oc_pkg::CH_W-1:0]    bg_c_s1;
	logic [rgba_oc_pkg::DEN_W-1:0]                          bg_wt_s1;
	logic [rgba_oc_pkg::CH_W-1:0]                           fg_alpha_s1;
	logic                                                   line_end_s1;
	logic                                                   frame_end_s1;

	// stage 2 registers
	logic                vld_s2;
	rgba_oc_pkg::pipe_t  word_s2;

	rgba_oc_pkg::pipe_t  word_nxt;
	logic [rgba_oc_pkg::DEN_W-1:0] den_nxt;
	logic [rgba_oc_pkg::DEN_W-1:0] alpha_sum;

	always_comb begin
		fg_c[rgba_oc_pkg::CH_RED]   = req.fg_red;
		fg_c[rgba_oc_pkg::CH_GREEN] = req.fg_green;
		fg_c[rgba_oc_pkg::CH_BLUE]  = req.fg_blue;
		bg_c[rgba_oc_pkg::CH_RED]   = req.bg_red;
		bg_c[rgba_oc_pkg::CH_GREEN] = req.bg_green;
		bg_c[rgba_oc_pkg::CH_BLUE]  = req.bg_blue;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
		end
	end

	// stage 1: fg alpha times colour, and the background weight (255-Aa)*Ba
	always_ff @(posedge clk) begin
		for (int c = 0; c < rgba_oc_pkg::N_CH; c++) begin
			fg_prod_s1[c] <= rgba_oc_pkg::DEN_W'(req.fg_alpha) *
				rgba_oc_pkg::DEN_W'(fg_c[c]);
		end
		bg_c_s1      <= bg_c;
		bg_wt_s1     <= rgba_oc_pkg::DEN_W'(rgba_oc_pkg::CH_MAX - req.fg_alpha) *
			rgba_oc_pkg::DEN_W'(req.bg_alpha);
		fg_alpha_s1  <= req.fg_alpha;
		line_end_s1  <= req.line_end_in;
		frame_end_s1 <= req.frame_end_in;
	end

	// stage 2: numerators 255*p + w*Bc, D = 255*Aa + w, alpha = D/255
	always_comb begin
		den_nxt = {fg_alpha_s1, 8'd0} - rgba_oc_pkg::DEN_W'(fg_alpha_s1) + bg_wt_s1;
		// exact divide by 255 for any value up to 65279, which covers every D
		alpha_sum = den_nxt + 16'd1 + {8'd0, den_nxt[15:8]};
		word_nxt.zero      = (den_nxt == '0);
		word_nxt.den       = den_nxt;
		word_nxt.alpha     = alpha_sum[15:8];
		word_nxt.line_end  = line_end_s1;
		word_nxt.frame_end = frame_end_s1;
		for (int c = 0; c < rgba_oc_pkg::N_CH; c++) begin
			word_nxt.rem[c] = {fg_prod_s1[c], 8'd0} -
				rgba_oc_pkg::NUM_W'(fg_prod_s1[c]) +
				rgba_oc_pkg::NUM_W'(bg_wt_s1) * rgba_oc_pkg::NUM_W'(bg_c_s1[c]);
			word_nxt.quot[c] = '0;
		end
	end

	always_ff @(posedge clk) begin
		word_s2 <= word_nxt;
	end

	assign vld_out = vld_s2;
	assign word    = word_s2;

endmodule
`default_nettype wire

/* design/rgba_oc_divider.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_oc_divider: pipelined restoring divider for the three colour channels
// four stages, two quotient bits per stage, msb first
// ----------------------------------------------------------------------------
module rgba_oc_divider (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               vld,
	input  wire rgba_oc_pkg::pipe_t word,
	output logic                    vld_out,
	output rgba_oc_pkg::pipe_t      result
);

	logic vld_s3, vld_s4, vld_s5, vld_s6;
	rgba_oc_pkg::pipe_t div_s3, div_s4, div_s5, div_s6;

	// two compare-subtract steps on every channel, quotient bits hi and hi-1
	function automatic rgba_oc_pkg::pipe_t div_step(input rgba_oc_pkg::pipe_t p,
		input int hi);
		rgba_oc_pkg::pipe_t r;
		logic [rgba_oc_pkg::NUM_W-1:0] sh;
		r = p;
		for (int c = 0; c < rgba_oc_pkg::N_CH; c++) begin
			for (int k = 0; k < rgba_oc_pkg::QBIT_PER_STAGE; k++) begin
				sh = rgba_oc_pkg::NUM_W'(p.den) << (hi - k);
				if (r.rem[c] >= sh) begin
					r.rem[c]  = r.rem[c] - sh;
					r.quot[c][hi - k] = 1'b1;
				end
			end
		end
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else begin
			vld_s3 <= vld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		div_s3 <= div_step(word,   7);
		div_s4 <= div_step(div_s3, 5);
		div_s5 <= div_step(div_s4, 3);
		div_s6 <= div_step(div_s5, 1);
	end

	assign vld_out = vld_s6;
	assign result  = div_s6;

endmodule
`default_nettype wire

/* design/rgba_over_composite_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// rgba_over_composite_top: porter-duff a-over-b for straight-alpha rgba8
// foreground over background, one pixel pair per clock, straight-alpha result
// ----------------------------------------------------------------------------
// usage
//  - a request (fg and bg pixel plus line and frame end markers) is taken on
//    the rising edge where start is high and busy is low
//  - busy never rises: the pipeline has no stall, so a request can be
//    issued on every clock, one pixel per cycle sustained
//  - the result appears on res with done high for exactly one cycle,
//    in request order
//  - the pipe is two product stages and a four-stage restoring
//    divider retiring two quotient bits per stage on each channel
//  - the receiver cannot hold results off; it must take each one as it comes
//  - reset clears the valid bits only, so nothing is emitted after reset
//    until a new request is taken; payload registers are left as they are
//  - both alphas zero gives an all-zero pixel, markers still copied through
//  - line and frame end markers ride along untouched
// ----------------------------------------------------------------------------
module rgba_over_composite_top (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	output logic                       busy,
	input  wire rgba_oc_pkg::pix_req_t req,
	output logic                       done,
	output rgba_oc_pkg::pix_res_t      res
);

	logic               front_vld;
	rgba_oc_pkg::pipe_t front_word;
	logic               div_vld;
	rgba_oc_pkg::pipe_t div_word;
	logic               take;

	// no back-pressure anywhere in the pipe
	assign busy = 1'b0;
	assign take = start & ~busy;

	// numerators, D and output alpha
	rgba_oc_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (take),
		.req     (req),
		.vld_out (front_vld),
		.word    (front_word)
	);

	// per-channel quotients
	rgba_oc_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (front_vld),
		.word    (front_word),
		.vld_out (div_vld),
		.result  (div_word)
	);

	// D of zero would give all-ones quotients, force the fully clear pixel
	always_comb begin
		if (div_word.zero) begin
			res.out_red   = '0;
			res.out_green = '0;
			res.out_blue  = '0;
			res.out_alpha = '0;
		end else begin
			res.out_red   = div_word.quot[rgba_oc_pkg::CH_RED];
			res.out_green = div_word.quot[rgba_oc_pkg::CH_GREEN];
			res.out_blue  = div_word.quot[rgba_oc_pkg::CH_BLUE];
			res.out_alpha = div_word.alpha;
		end
		res.line_end_out  = div_word.line_end;
		res.frame_end_out = div_word.frame_end;
	end

	assign done = div_vld;

endmodule
`default_nettype wire

/* verif/rgba_over_composite_top_tb.sv */
// ----------------------------------------------------------------------------
// rgba_over_composite_top_tb: self-checking bench for the a-over-b compositor
// feeds directed corner pixels, then framed random pixel streams under three
// sender idle settings, and checks every result against an exact integer
// predictor of the straight-alpha over operator
// ----------------------------------------------------------------------------
module rgba_over_composite_top_tb;

	localparam int unsigned FULL       = 255;
	localparam int unsigned STALL_MAX  = 500;
	localparam int unsigned TAIL_CYC   = 8;
	localparam int unsigned PHASE_REQS = 465;

	// one pending request plus how the sender treats it
	typedef struct {
		rgba_oc_pkg::pix_req_t px;
		int unsigned           idle_pct;
		bit                    settle;
	} feed_t;

	// predicted pixel, kept with the request that caused it
	typedef struct {
		rgba_oc_pkg::pix_req_t src;
		rgba_oc_pkg::pix_res_t px;
	} blend_t;

	logic                  clk    = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  start  = 1'b0;
	rgba_oc_pkg::pix_req_t req    = '0;
	logic                  busy;
	logic                  done;
	rgba_oc_pkg::pix_res_t res;

	feed_t       pixel_in_q[$];
	blend_t      blend_q[$];
	int unsigned n_queued  = 0;
	int unsigned n_taken   = 0;
	int unsigned n_checked = 0;
	int unsigned n_clear   = 0;
	int unsigned n_frames  = 0;
	int unsigned err_cnt   = 0;
	int unsigned quiet_cyc = 0;

	rgba_over_composite_top DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// predictor: exact integer form of straight-alpha a over b
	// ------------------------------------------------------------------------
	function automatic logic [7:0] blend_ch(int unsigned fg_w, int unsigned bg_w,
			logic [7:0] fg_c, logic [7:0] bg_c, int unsigned den);
		return 8'((fg_w * fg_c + bg_w * bg_c) / den);
	endfunction

	function automatic rgba_oc_pkg::pix_res_t over_pixel(rgba_oc_pkg::pix_req_t p);
		int unsigned           fa, ba, den, fg_w, bg_w;
		rgba_oc_pkg::pix_res_t r;
		fa  = p.fg_alpha;
		ba  = p.bg_alpha;
		// combined coverage, scaled by 255; zero only when both alphas are clear
		den = FULL * FULL - (FULL - fa) * (FULL - ba);
		r   = '0;
		if (den != 0) begin
			fg_w        = FULL * fa;
			bg_w        = (FULL - fa) * ba;
			r.out_red   = blend_ch(fg_w, bg_w, p.fg_red, p.bg_red, den);
			r.out_green = blend_ch(fg_w, bg_w, p.fg_green, p.bg_green, den);
			r.out_blue  = blend_ch(fg_w, bg_w, p.fg_blue, p.bg_blue, den);
			r.out_alpha = 8'(den / FULL);
		end
		// markers ride through whatever the alphas are
		r.line_end_out  = p.line_end_in;
		r.frame_end_out = p.frame_end_in;
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	function automatic rgba_oc_pkg::pix_req_t pixel_pair(int fr, int fgc, int fb, int fa,
			int br, int bgc, int bb, int ba, bit le, bit fe);
		rgba_oc_pkg::pix_req_t p;
		p.fg_red       = 8'(fr);
		p.fg_green     = 8'(fgc);
		p.fg_blue      = 8'(fb);
		p.fg_alpha     = 8'(fa);
		p.bg_red       = 8'(br);
		p.bg_green     = 8'(bgc);
		p.bg_blue      = 8'(bb);
		p.bg_alpha     = 8'(ba);
		p.line_end_in  = le;
		p.frame_end_in = fe;
		return p;
	endfunction

	// leans towards the ends of the range, where the divide is most delicate
	function automatic logic [7:0] rand_level();
		case ($urandom_range(7))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'($urandom_range(3, 1));
			3: return 8'($urandom_range(254, 252));
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic rgba_oc_pkg::pix_req_t random_pixel();
		return pixel_pair(rand_level(), rand_level(), rand_level(), rand_level(),
			rand_level(), rand_level(), rand_level(), rand_level(),
			$urandom_range(1), $urandom_range(1));
	endfunction

	task automatic add_pixel(rgba_oc_pkg::pix_req_t p, int unsigned idle_pct, bit settle);
		feed_t f;
		f.px       = p;
		f.idle_pct = idle_pct;
		f.settle   = settle;
		pixel_in_q.push_back(f);
		n_queued++;
	endtask

	// one raster of random size; now and then the markers are scrambled
	task automatic add_frame(int unsigned idle_pct);
		int unsigned           w, h;
		bit                    noisy;
		rgba_oc_pkg::pix_req_t p;
		w     = $urandom_range(12, 1);
		h     = $urandom_range(4, 1);
		noisy = ($urandom_range(7) == 0);
		for (int unsigned y = 0; y < h; y++) begin
			for (int unsigned x = 0; x < w; x++) begin
				p = random_pixel();
				if (!noisy) begin
					p.line_end_in  = (x == w - 1);
					p.frame_end_in = (x == w - 1) && (y == h - 1);
				end
				add_pixel(p, idle_pct, $urandom_range(59) == 0);
			end
		end
	endtask

	task automatic report_mismatch(string msg);
		$display("[%0t] error: %s", $time, msg);
		err_cnt++;
	endtask

	task automatic check_field(string fld, logic [7:0] got, logic [7:0] want,
			rgba_oc_pkg::pix_req_t src);
		if (got !== want)
			report_mismatch($sformatf("%s got %0d want %0d (fg %h_%h_%h_%h bg %h_%h_%h_%h)",
				fld, got, want, src.fg_red, src.fg_green, src.fg_blue, src.fg_alpha,
				src.bg_red, src.bg_green, src.bg_blue, src.bg_alpha));
	endtask

	// ------------------------------------------------------------------------
	// driver: takes the next request from the pending queue, holds it while
	// busy, idles at random, and waits for the pipe to empty on settle items
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin : drv
		bit took, go;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			took = start && !busy;
			if (took) begin
				blend_q.push_back('{src: req, px: over_pixel(req)});
				void'(pixel_in_q.pop_front());
				n_taken++;
				if (req.fg_alpha == 0 && req.bg_alpha == 0)
					n_clear++;
				if (req.frame_end_in)
					n_frames++;
			end
			if (start && !took) begin
				// request still pending, keep it on the bus
			end else begin
				go = 1'b0;
				if (pixel_in_q.size() != 0) begin
					// a result landing this edge means the pipe is not yet empty
					if (pixel_in_q[0].settle)
						go = (blend_q.size() == 0) && !done;
					else
						go = $urandom_range(99) >= pixel_in_q[0].idle_pct;
				end
				start <= go;
				if (go)
					req <= pixel_in_q[0].px;
			end
		end
	end

	// ------------------------------------------------------------------------
	// monitor: every strobed result is matched against the oldest prediction
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : mon
		blend_t want;
		if (arst_n && done) begin
			if (blend_q.size() == 0) begin
				report_mismatch("result strobed with no request outstanding");
			end else begin
				want = blend_q.pop_front();
				check_field("red", res.out_red, want.px.out_red, want.src);
				check_field("green", res.out_green, want.px.out_green, want.src);
				check_field("blue", res.out_blue, want.px.out_blue, want.src);
				check_field("alpha", res.out_alpha, want.px.out_alpha, want.src);
				check_field("line_end", res.line_end_out, want.px.line_end_out, want.src);
				check_field("frame_end", res.frame_end_out, want.px.frame_end_out,
					want.src);
				n_checked++;
			end
		end
	end

	// watchdog: too long without a request taken or a result seen
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cyc = 0;
			else
				quiet_cyc++;
			if (quiet_cyc >= STALL_MAX) begin
				$display("[%0t] watchdog: no progress, %0d results outstanding",
					$time, blend_q.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus plan and end of run
	// ------------------------------------------------------------------------
	initial begin : plan
		int unsigned idle_plan[3];
		int unsigned n_directed;
		idle_plan = '{17, 62, 0};

		// both alphas clear, with every marker combination
		add_pixel(pixel_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(255, 255, 255, 0, 255, 255, 255, 0, 1, 1), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(170, 85, 1, 0, 254, 3, 128, 0, 1, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(9, 200, 77, 0, 60, 33, 250, 0, 0, 1), idle_plan[0], 1'b0);
		// opaque foreground hides the background
		add_pixel(pixel_pair(255, 0, 128, 255, 0, 255, 7, 255, 0, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(12, 34, 56, 255, 200, 100, 50, 0, 1, 0), idle_plan[0], 1'b0);
		// clear foreground shows the background
		add_pixel(pixel_pair(255, 255, 255, 0, 1, 128, 254, 255, 0, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(255, 0, 255, 0, 255, 0, 255, 1, 0, 0), idle_plan[0], 1'b0);
		// faintest single-side coverage
		add_pixel(pixel_pair(255, 128, 1, 1, 0, 0, 0, 0, 0, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(255, 255, 255, 255, 255, 255, 255, 255, 1, 1), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(255, 255, 255, 1, 255, 255, 255, 1, 0, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(255, 255, 255, 1, 0, 0, 0, 1, 0, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(255, 0, 255, 254, 0, 255, 0, 254, 0, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(200, 100, 0, 128, 0, 100, 255, 127, 0, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(255, 255, 255, 1, 0, 0, 0, 254, 0, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(0, 0, 0, 254, 255, 255, 255, 1, 0, 1), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(0, 0, 0, 255, 255, 255, 255, 255, 1, 0), idle_plan[0], 1'b0);
		add_pixel(pixel_pair(254, 1, 127, 3, 1, 254, 129, 252, 0, 0), idle_plan[0], 1'b0);
		n_directed = n_queued;

		// three idle settings; each opens by letting the pipe run dry
		for (int ph = 0; ph < 3; ph++) begin
			add_pixel(random_pixel(), idle_plan[ph], 1'b1);
			while (n_queued < n_directed + (ph + 1) * PHASE_REQS)
				add_frame(idle_plan[ph]);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (pixel_in_q.size() != 0 || blend_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYC) @(posedge clk);

		$display("covered %0d requests (%0d directed) in %0d frame ends, %0d %s",
			n_taken, n_directed, n_frames, n_clear, "with both alphas clear");
		$display("checked %0d results across sender idle rates of %s, %0d errors",
			n_checked, "17, 62 and 0 percent", err_cnt);
		if (err_cnt == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
